### rtl/tstg_pkg.sv
// Shared types, constants and the quarter sine table builder for the tone generator.
package tstg_pkg;

	// Quarter table geometry
	localparam int TABLE_SIZE = 256;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int FRAC_W     = 16;
	localparam int PHASE_W    = IDX_W + FRAC_W + 1;
	localparam int SUM_W      = PHASE_W + 2;

	// Triangle level, Q2.24
	localparam int LEVEL_W    = 28;
	localparam int TRI_STEP_W = 26;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 26;

	localparam logic signed [LEVEL_W-1:0] TRI_ONE       = 28'sd16777216;
	localparam logic signed [LEVEL_W-1:0] TRI_TWO       = 28'sd33554432;
	localparam logic signed [LEVEL_W-1:0] TRI_MINUS_ONE = -28'sd16777216;
	localparam logic signed [LEVEL_W-1:0] TRI_MINUS_TWO = -28'sd33554432;
	localparam logic signed [LEVEL_W-1:0] TRI_ROUND     = 28'sd256;
	localparam logic signed [LEVEL_W-1:0] TRI_SAT       = 28'sd32767;
	localparam logic [TRI_STEP_W-1:0]     TRI_STEP_MAX  = 26'd33554432;

	localparam logic [PHASE_W-1:0] PHASE_END = PHASE_W'(TABLE_SIZE) << FRAC_W;
	localparam logic signed [SUM_W-1:0] PHASE_END_S = SUM_W'(TABLE_SIZE) << FRAC_W;
	localparam logic signed [SUM_W-1:0] PHASE_TWO_END_S = SUM_W'(TABLE_SIZE) << (FRAC_W + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_SELECT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIANGLE_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SINE_STEP     = 2'd2;

	typedef enum logic {
		WAVE_TRIANGLE = 1'b0,
		WAVE_SINE     = 1'b1
	} wave_t;

	// Per-oscillator control for one transfer
	typedef struct packed {
		logic load;     // reload start state first
		logic advance;  // step this oscillator
	} osc_ctrl_t;

	typedef logic [SAMPLE_W-1:0] rom_t [TABLE_SIZE];

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	function automatic logic [63:0] next_term(logic [63:0] term, logic [63:0] x);
		logic [63:0] t;
		t = (term * x) >> 30;
		t = (t * x) >> 30;
		return t;
	endfunction

	// sin(x) for x in Q30 over the first quadrant, Taylor series to x^17
	function automatic logic signed [63:0] sin_q30(logic [63:0] x);
		logic [63:0]        term;
		logic signed [63:0] sum;
		term = x;
		sum  = signed'(x);
		term = next_term(term, x) / 64'd6;   sum = sum - signed'(term);
		term = next_term(term, x) / 64'd20;  sum = sum + signed'(term);
		term = next_term(term, x) / 64'd42;  sum = sum - signed'(term);
		term = next_term(term, x) / 64'd72;  sum = sum + signed'(term);
		term = next_term(term, x) / 64'd110; sum = sum - signed'(term);
		term = next_term(term, x) / 64'd156; sum = sum + signed'(term);
		term = next_term(term, x) / 64'd210; sum = sum - signed'(term);
		term = next_term(term, x) / 64'd272; sum = sum + signed'(term);
		return sum;
	endfunction

	// Quarter sine table, entry i = round(32767 * sin(i*pi/(2*TABLE_SIZE)))
	function automatic rom_t build_rom();
		rom_t               r;
		logic [63:0]        x;
		logic signed [63:0] s;
		logic [63:0]        v;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			x = (HALF_PI_Q30 * 64'(i)) / TABLE_SIZE;
			s = sin_q30(x);
			if (s < 0) begin
				s = 0;
			end
			v = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			r[i] = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/tstg_rom.sv
// Quarter-wave sine lookup table, built at elaboration.
module tstg_rom (
	input  logic [tstg_pkg::IDX_W-1:0]    idx,
	output logic [tstg_pkg::SAMPLE_W-1:0] data
);
	import tstg_pkg::*;

	localparam rom_t ROM = build_rom();

	assign data = ROM[idx];

endmodule

### rtl/tstg_tri.sv
// Triangle oscillator: Q2.24 level with reflection at +1 and -1.
module tstg_tri (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tstg_pkg::osc_ctrl_t                 ctrl,
	input  logic [tstg_pkg::TRI_STEP_W-1:0]     step,
	output logic signed [tstg_pkg::SAMPLE_W-1:0] sample_nxt
);
	import tstg_pkg::*;

	logic signed [LEVEL_W-1:0] level_q;
	logic                      falling_q;

	logic signed [LEVEL_W-1:0] base_level;
	logic                      base_falling;
	logic [TRI_STEP_W-1:0]     st;
	logic signed [LEVEL_W-1:0] st_s;
	logic signed [LEVEL_W-1:0] sum;
	logic signed [LEVEL_W-1:0] level_nxt;
	logic                      falling_nxt;
	logic signed [LEVEL_W-1:0] rounded;

	always_comb begin
		base_level   = ctrl.load ? TRI_MINUS_ONE : level_q;
		base_falling = ctrl.load ? 1'b0 : falling_q;
		st           = (step > TRI_STEP_MAX) ? TRI_STEP_MAX : step;
		st_s         = signed'({{(LEVEL_W - TRI_STEP_W){1'b0}}, st});
		sum          = base_falling ? (base_level - st_s) : (base_level + st_s);
		level_nxt    = sum;
		falling_nxt  = base_falling;
		if (sum > TRI_ONE) begin
			level_nxt   = TRI_TWO - sum;
			falling_nxt = ~base_falling;
		end else if (sum < TRI_MINUS_ONE) begin
			level_nxt   = TRI_MINUS_TWO - sum;
			falling_nxt = ~base_falling;
		end
		// round half up to Q1.15, saturate +1.0
		rounded = (level_nxt + TRI_ROUND) >>> 9;
		if (rounded > TRI_SAT) begin
			sample_nxt = SAMPLE_MAX;
		end else begin
			sample_nxt = rounded[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= TRI_MINUS_ONE;
			falling_q <= 1'b0;
		end else if (ctrl.advance) begin
			level_q   <= level_nxt;
			falling_q <= falling_nxt;
		end else if (ctrl.load) begin
			level_q   <= TRI_MINUS_ONE;
			falling_q <= 1'b0;
		end
	end

endmodule

### rtl/tstg_sine.sv
// Sine oscillator: phase walks up and down a quarter table, sign toggles at zero.
module tstg_sine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tstg_pkg::osc_ctrl_t                  ctrl,
	input  logic [tstg_pkg::PHASE_W-1:0]         step,
	output logic signed [tstg_pkg::SAMPLE_W-1:0] sample_nxt
);
	import tstg_pkg::*;

	logic [PHASE_W-1:0]      phase_q;
	logic                    desc_q;
	logic                    neg_q;

	logic [PHASE_W-1:0]      base_phase;
	logic                    base_desc;
	logic                    base_neg;
	logic [PHASE_W-1:0]      d;
	logic signed [SUM_W-1:0] d_s;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] refl;
	logic [PHASE_W-1:0]      phase_nxt;
	logic                    desc_nxt;
	logic                    neg_nxt;
	logic [IDX_W:0]          idx_wide;
	logic [IDX_W-1:0]        idx;
	logic [SAMPLE_W-1:0]     rom_data;

	always_comb begin
		base_phase = ctrl.load ? '0 : phase_q;
		base_desc  = ctrl.load ? 1'b0 : desc_q;
		base_neg   = ctrl.load ? 1'b0 : neg_q;
		d          = (step > PHASE_END) ? PHASE_END : step;
		d_s        = signed'({2'b00, d});
		sum        = base_desc ? (signed'({2'b00, base_phase}) - d_s)
		                       : (signed'({2'b00, base_phase}) + d_s);
		refl       = sum;
		desc_nxt   = base_desc;
		neg_nxt    = base_neg;
		if (sum >= PHASE_END_S) begin
			refl     = PHASE_TWO_END_S - sum;
			desc_nxt = ~base_desc;
		end else if (sum < 0) begin
			refl     = -sum;
			desc_nxt = ~base_desc;
			neg_nxt  = ~base_neg;
		end
		phase_nxt = refl[PHASE_W-1:0];
		// clamp the lookup at the reflection point to the last entry
		idx_wide  = phase_nxt[PHASE_W-1:FRAC_W];
		idx       = (idx_wide > {1'b0, IDX_LAST}) ? IDX_LAST : idx_wide[IDX_W-1:0];
	end

	tstg_rom u_rom (
		.idx  (idx),
		.data (rom_data)
	);

	assign sample_nxt = neg_nxt ? -signed'(rom_data) : signed'(rom_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			desc_q  <= 1'b0;
			neg_q   <= 1'b0;
		end else if (ctrl.advance) begin
			phase_q <= phase_nxt;
			desc_q  <= desc_nxt;
			neg_q   <= neg_nxt;
		end else if (ctrl.load) begin
			phase_q <= '0;
			desc_q  <= 1'b0;
			neg_q   <= 1'b0;
		end
	end

endmodule

### rtl/triangle_sine_tone_generator_core.sv
// Top level of the triangle and sine tone generator.
// One signed Q1.15 sample comes out for every input transfer. On each
// transfer the oscillator state advances and the new sample is formed in a
// single pass (add, reflect, then table read or rounding) and captured in the
// output register; a new transfer is taken in every cycle while the output
// register is empty or is being emptied in that cycle, so the
// sustained rate is one sample per clock when the receiver does not stall.
// wave_select picks the triangle (0) or the sine (1) oscillator; only the
// selected one advances, the other holds its state. A transfer with restart
// set reloads both oscillators (level -1.0 rising, phase 0 ascending,
// positive half) before the step. triangle_step saturates at 2.0 and
// sine_step at the table size. Configuration writes are always ready and
// must only be made while the generator is idle.
module triangle_sine_tone_generator_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tstg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tstg_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 restart,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [tstg_pkg::SAMPLE_W-1:0] sample
);
	import tstg_pkg::*;

	// Configuration registers
	wave_t                  wave_q;
	logic [TRI_STEP_W-1:0]  tri_step_q;
	logic [PHASE_W-1:0]     sine_step_q;

	// Output register
	logic                   out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic                   in_take;
	osc_ctrl_t              tri_ctrl;
	osc_ctrl_t              sine_ctrl;
	logic signed [SAMPLE_W-1:0] tri_sample;
	logic signed [SAMPLE_W-1:0] sine_sample;

	assign cfg_ready = 1'b1;

	// Take a new transfer whenever the output slot is free or drains this cycle
	assign in_stall = out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	// Reload both oscillators on restart; advance only the selected one
	assign tri_ctrl.load     = in_take && restart;
	assign tri_ctrl.advance  = in_take && (wave_q == WAVE_TRIANGLE);
	assign sine_ctrl.load    = in_take && restart;
	assign sine_ctrl.advance = in_take && (wave_q == WAVE_SINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q      <= WAVE_SINE;
			tri_step_q  <= '0;
			sine_step_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WAVE_SELECT:   wave_q      <= wave_t'(cfg_data[0]);
				REG_TRIANGLE_STEP: tri_step_q  <= cfg_data[TRI_STEP_W-1:0];
				REG_SINE_STEP:     sine_step_q <= cfg_data[PHASE_W-1:0];
				default: ;  // drop writes to unused indexes
			endcase
		end
	end

	tstg_tri u_tri (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (tri_ctrl),
		.step       (tri_step_q),
		.sample_nxt (tri_sample)
	);

	tstg_sine u_sine (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (sine_ctrl),
		.step       (sine_step_q),
		.sample_nxt (sine_sample)
	);

	// Capture the sample on each transfer; hold it while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= (wave_q == WAVE_SINE) ? sine_sample : tri_sample;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	// A transfer always leaves a result in the output register
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> out_valid)
		else $error("accepted transfer produced no result");

	// A result that drained with no new transfer behind it is gone
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_take && out_valid && !out_stall) |=> !out_valid)
		else $error("result repeated without a transfer");

	// Restart with a zero sine step sits at the table origin
	a_sine_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && restart && (wave_q == WAVE_SINE) && (sine_step_q == '0))
		|=> (sample == '0))
		else $error("sine restart did not give zero");

	// Restart with a zero triangle step sits at -1.0
	a_tri_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && restart && (wave_q == WAVE_TRIANGLE) && (tri_step_q == '0))
		|=> (sample == -16'sd32768))
		else $error("triangle restart did not give -1.0");

endmodule

### tb/triangle_sine_tone_generator_core_tb.sv
// Self-checking testbench for the triangle and sine tone generator core.
module triangle_sine_tone_generator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Fixed-point landmarks of the tone arithmetic
	localparam int LEVEL_ONE       = 1 << 24;          // +1.0 in Q2.24
	localparam int TRI_STEP_LIMIT  = 1 << 25;          // triangle step saturates at 2.0
	localparam int PHASE_TOP       = tstg_pkg::TABLE_SIZE << 16;
	localparam int ROM_LAST        = tstg_pkg::TABLE_SIZE - 1;
	localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

	localparam logic [25:0] TRI_STEP_ZERO  = 26'd0;
	localparam logic [25:0] TRI_STEP_TWO   = 26'd33554432;
	localparam logic [25:0] TRI_STEP_ONE   = 26'd16777216;
	localparam logic [25:0] TRI_STEP_ONES  = 26'h3FFFFFF;
	localparam logic [24:0] SINE_STEP_ZERO = 25'd0;
	localparam logic [24:0] SINE_STEP_FULL = 25'd16777216;
	localparam logic [24:0] SINE_STEP_ONES = 25'h1FFFFFF;

	localparam int RANDOM_PHASES   = 9;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int REPORT_LIMIT    = 20;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_kind_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [tstg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tstg_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic restart;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [tstg_pkg::SAMPLE_W-1:0] sample;

	// Shadow configuration and oscillator state
	tstg_pkg::wave_t wave_cfg;
	logic [25:0] tri_step_cfg;
	logic [24:0] sine_step_cfg;
	logic signed [27:0] tone_level;
	logic tone_falling;
	logic [24:0] tone_phase;
	logic tone_descending;
	logic tone_negative;
	logic [15:0] quarter_table [tstg_pkg::TABLE_SIZE];

	// Samples still owed by the generator, oldest first
	logic signed [15:0] pending_samples [$];

	// Sender pacing
	int max_gap = 0;
	int burst_left = 0;

	// Receiver stall pattern
	stall_kind_t stall_mode = STALL_NONE;
	int stall_left = 0;

	// Run statistics
	int transfers_sent = 0;
	int restarts_sent = 0;
	int samples_checked = 0;
	int reg_writes = 0;
	int fault_count = 0;
	int idle_cycles = 0;

	triangle_sine_tone_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.restart   (restart),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Build the quarter sine table: Taylor series of sin in Q30, rounded to Q1.15
	function automatic void fill_quarter_table();
		longint unsigned x;
		longint unsigned term;
		longint acc;
		longint unsigned v;
		for (int i = 0; i < tstg_pkg::TABLE_SIZE; i++) begin
			x = (QUARTER_TURN_Q30 * longint'(i)) / tstg_pkg::TABLE_SIZE;
			term = x;
			acc = longint'(x);
			for (int k = 1; k <= 8; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / longint'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			v = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
			if (v > 32767) begin
				v = 32767;
			end
			quarter_table[i] = v[15:0];
		end
	endfunction

	// Start state of both oscillators: level -1.0 rising, phase 0 ascending, positive
	function automatic void load_start_state();
		tone_level = -28'sd16777216;
		tone_falling = 1'b0;
		tone_phase = '0;
		tone_descending = 1'b0;
		tone_negative = 1'b0;
	endfunction

	// Advance the selected oscillator by one tick and give the sample it produces
	function automatic logic signed [15:0] next_tone_sample(input logic reload);
		int lvl;
		int tstep;
		int ph;
		int sstep;
		int level_out;
		int idx;
		int s;
		if (reload) begin
			load_start_state();
		end
		if (wave_cfg == tstg_pkg::WAVE_TRIANGLE) begin
			tstep = (int'(tri_step_cfg) > TRI_STEP_LIMIT) ? TRI_STEP_LIMIT : int'(tri_step_cfg);
			lvl = int'(tone_level) + (tone_falling ? -tstep : tstep);
			// reflect off the rails
			if (lvl > LEVEL_ONE) begin
				lvl = 2 * LEVEL_ONE - lvl;
				tone_falling = !tone_falling;
			end else if (lvl < -LEVEL_ONE) begin
				lvl = -2 * LEVEL_ONE - lvl;
				tone_falling = !tone_falling;
			end
			tone_level = lvl[27:0];
			// round Q2.24 to Q1.15 half up, saturate +1.0
			level_out = ((lvl + (1 << 25) + 256) >>> 9) - (1 << 16);
			if (level_out > 32767) begin
				level_out = 32767;
			end
			if (level_out < -32768) begin
				level_out = -32768;
			end
			s = level_out;
		end else begin
			sstep = (int'(sine_step_cfg) > PHASE_TOP) ? PHASE_TOP : int'(sine_step_cfg);
			ph = int'(tone_phase) + (tone_descending ? -sstep : sstep);
			if (ph >= PHASE_TOP) begin
				ph = 2 * PHASE_TOP - ph;
				tone_descending = !tone_descending;
			end else if (ph < 0) begin
				ph = -ph;
				tone_descending = !tone_descending;
				tone_negative = !tone_negative;
			end
			tone_phase = ph[24:0];
			idx = ph >> 16;
			// the reflection point itself reads the last entry
			if (idx > ROM_LAST) begin
				idx = ROM_LAST;
			end
			s = int'(quarter_table[idx]);
			if (tone_negative) begin
				s = -s;
			end
		end
		return s[15:0];
	endfunction

	// Offer one tone transfer, hold it through stalls, then log its expected sample
	task automatic send_tick(input logic reload);
		in_valid <= 1'b1;
		restart <= reload;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		pending_samples.push_back(next_tone_sample(reload));
		transfers_sent++;
		if (reload) begin
			restarts_sent++;
		end
		// end of burst: drop valid for a random gap, with noise on restart
		if (burst_left > 0) begin
			burst_left--;
		end else if (max_gap > 0) begin
			in_valid <= 1'b0;
			restart <= 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, max_gap)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	// Stop offering transfers and wait until every owed sample has been taken
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_samples.size() != 0);
	endtask

	// Write all three registers back to back while the generator is idle
	task automatic program_tone(input tstg_pkg::wave_t w, input logic [25:0] tstep,
			input logic [24:0] sstep);
		logic [tstg_pkg::CFG_IDX_W-1:0] idx [3];
		logic [25:0] val [3];
		idx[0] = tstg_pkg::REG_WAVE_SELECT;
		val[0] = 26'(w);
		idx[1] = tstg_pkg::REG_TRIANGLE_STEP;
		val[1] = tstep;
		idx[2] = tstg_pkg::REG_SINE_STEP;
		val[2] = 26'(sstep);
		hold_until_drained();
		// let the output register settle before the register writes
		repeat (2) @(posedge clk);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready) begin
				@(posedge clk);
			end
			reg_writes++;
			case (idx[i])
				tstg_pkg::REG_WAVE_SELECT:   wave_cfg = tstg_pkg::wave_t'(val[i][0]);
				tstg_pkg::REG_TRIANGLE_STEP: tri_step_cfg = val[i];
				tstg_pkg::REG_SINE_STEP:     sine_step_cfg = val[i][24:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Sine at power-up: reset config selects sine with a zero step
	task automatic test_power_up_sine();
		max_gap = 0;
		send_tick(1'b0);
		send_tick(1'b0);
	endtask

	// Triangle: zero step, full 2.0 step, oversized step, 1.0 step
	task automatic test_triangle_limits();
		program_tone(tstg_pkg::WAVE_TRIANGLE, TRI_STEP_ZERO, SINE_STEP_ZERO);
		send_tick(1'b0);
		// a 2.0 step bounces rail to rail; +1.0 saturates
		program_tone(tstg_pkg::WAVE_TRIANGLE, TRI_STEP_TWO, SINE_STEP_ZERO);
		repeat (3) send_tick(1'b0);
		// above 2.0 must clamp
		program_tone(tstg_pkg::WAVE_TRIANGLE, TRI_STEP_ONES, SINE_STEP_ONES);
		repeat (2) send_tick(1'b0);
		program_tone(tstg_pkg::WAVE_TRIANGLE, TRI_STEP_ONE, SINE_STEP_ZERO);
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
	endtask

	// Sine: step of a whole table hits both reflections and the clamped lookup
	task automatic test_sine_limits();
		program_tone(tstg_pkg::WAVE_SINE, TRI_STEP_ONES, SINE_STEP_FULL);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
		// oversized step must clamp to the table size
		program_tone(tstg_pkg::WAVE_SINE, TRI_STEP_ZERO, SINE_STEP_ONES);
		repeat (2) send_tick(1'b0);
		program_tone(tstg_pkg::WAVE_SINE, TRI_STEP_ZERO, 25'h0E8_8001);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
	endtask

	// Swap modes mid-wave: the idle oscillator keeps its state
	task automatic test_mode_switch_hold();
		program_tone(tstg_pkg::WAVE_TRIANGLE, 26'd4194304, 25'd1048576);
		repeat (2) send_tick(1'b0);
		program_tone(tstg_pkg::WAVE_SINE, 26'd4194304, 25'd1048576);
		repeat (2) send_tick(1'b0);
		program_tone(tstg_pkg::WAVE_TRIANGLE, 26'd4194304, 25'd1048576);
		send_tick(1'b0);
	endtask

	// Random settings per phase, random restarts, random pacing on both sides
	task automatic test_random_tones();
		tstg_pkg::wave_t w;
		logic [25:0] ts;
		logic [24:0] ss;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			w = tstg_pkg::wave_t'((p + $urandom_range(0, 1)) % 2);
			case ($urandom_range(0, 5))
				0: ts = 26'($urandom_range(1, 1 << 16));
				1: ts = 26'($urandom_range(1 << 16, 1 << 22));
				2: ts = 26'($urandom_range(0, (1 << 26) - 1));
				3: ts = TRI_STEP_TWO;
				4: ts = 26'($urandom_range(TRI_STEP_LIMIT, (1 << 26) - 1));
				default: ts = TRI_STEP_ZERO;
			endcase
			case ($urandom_range(0, 5))
				0: ss = 25'($urandom_range(1, 1 << 16));
				1: ss = 25'($urandom_range(1 << 16, 1 << 21));
				2: ss = 25'($urandom_range(0, (1 << 25) - 1));
				3: ss = SINE_STEP_FULL;
				4: ss = 25'($urandom_range(PHASE_TOP, (1 << 25) - 1));
				default: ss = SINE_STEP_ZERO;
			endcase
			program_tone(w, ts, ss);
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = $urandom_range(0, 12);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// once mid-run, hold the sender back until the pipe is empty
				if (p == 3 && n == ITEMS_PER_PHASE / 2) begin
					hold_until_drained();
				end
				send_tick($urandom_range(0, 31) == 0);
			end
		end
	endtask

	// Receiver: stall on a pattern that changes style after a random run length
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_kind_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(40, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= (stall_left % 5 < 2);
		endcase
	end

	// Compare each sample transfer with the oldest owed sample
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n && out_valid && !out_stall) begin
			samples_checked++;
			if (pending_samples.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT) begin
					$display("%0t: unexpected sample %0d, expected none", $time, sample);
				end
			end else begin
				want = pending_samples.pop_front();
				if (sample !== want) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT) begin
						$display("%0t: sample mismatch, expected %0d, actual %0d",
							$time, want, sample);
					end
				end
			end
		end
	end

	// Watchdog: give up when no transfer of any kind happens for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d samples still owed",
					$time, idle_cycles, pending_samples.size());
				$display("triangle_sine_tone_generator_core test failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= tstg_pkg::REG_WAVE_SELECT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		restart <= 1'b0;
		fill_quarter_table();
		// shadow of the reset configuration
		wave_cfg = tstg_pkg::WAVE_SINE;
		tri_step_cfg = '0;
		sine_step_cfg = '0;
		load_start_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_sine();
		test_triangle_limits();
		test_sine_limits();
		test_mode_switch_hold();
		test_random_tones();

		// drain, then let the output register settle
		hold_until_drained();
		repeat (4) @(posedge clk);

		$display("Run covered %0d tone transfers (%0d with restart) over %0d register writes,",
			transfers_sent, restarts_sent, reg_writes);
		$display("both wave shapes, step saturation and reflections; %0d samples compared.",
			samples_checked);
		if (fault_count == 0 && pending_samples.size() == 0) begin
			$display("triangle_sine_tone_generator_core test passed");
		end else begin
			$display("triangle_sine_tone_generator_core test failed");
		end
		$finish;
	end

endmodule
